>>> rtl/core/ubx_fb_pkg.sv
// Shared types and constants for the UBX frame builder.
`timescale 1ns / 1ps

package ubx_fb_pkg;

   // Frame sync bytes.
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // Longest burst of bytes that one input word expands into.
   localparam int unsigned MAX_BYTES  = 8;
   localparam int unsigned CNT_W      = $clog2(MAX_BYTES + 1);

   // Input word widths.
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;

   // Kind of input word, carried on tuser.
   typedef enum logic {
      OP_START   = 1'b0,
      OP_PAYLOAD = 1'b1
   } op_type;

   // One input word after unpacking.
   typedef struct packed {
      op_type      operation;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
   } item_type;

endpackage

>>> rtl/core/ubx_fb_hold.sv
// Input register stage: holds one accepted request word for the core.
`timescale 1ns / 1ps

module ubx_fb_hold (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ubx_fb_pkg::item_type in_item,
   output logic                 out_valid,
   input  logic                 out_take,
   output ubx_fb_pkg::item_type out_item
);

   logic                 valid_ff;
   logic                 valid_in;
   ubx_fb_pkg::item_type item_ff;

   // The register frees up in the same cycle the core takes its word.
   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

>>> rtl/core/ubx_fb_core.sv
// Frame state, checksum update, byte burst buffer and output register.
`timescale 1ns / 1ps

module ubx_fb_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_take,
   input  ubx_fb_pkg::item_type item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_byte,
   output logic                 out_frame_end,
   output logic                 out_run_last
);

   localparam int unsigned N = ubx_fb_pkg::MAX_BYTES;
   localparam int unsigned W = ubx_fb_pkg::CNT_W;

   // Frame state.
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [15:0] left_ff, left_in;
   logic        open_ff, open_in;

   // Burst buffer: slot 0 is the next byte to send.
   logic [7:0]  bytes_ff [N];
   logic [7:0]  bytes_in [N];
   logic [N-1:0] ends_ff, ends_in;
   logic [W-1:0] count_ff, count_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_end_ff;
   logic        rsp_last_ff;

   // Expansion of the held word.
   logic [7:0]  exp_bytes [N];
   logic [N-1:0] exp_ends;
   logic [W-1:0] exp_count;
   logic [7:0]  a1, b1, a2, b2, a3, b3, a4, b4;
   logic [7:0]  pa, pb;
   logic        busy, out_free, emit, last_emit;

   assign busy      = (count_ff != '0);
   assign out_free  = !rsp_valid_ff || out_ready;
   assign emit      = busy && out_free;
   assign last_emit = emit && (count_ff == W'(1));
   assign item_take = item_valid && (!busy || last_emit);

   // Header checksum chain over class, id and the two length bytes.
   always_comb begin
      a1 = item.msg_class;
      b1 = a1;
      a2 = a1 + item.msg_id;
      b2 = b1 + a2;
      a3 = a2 + item.payload_length[7:0];
      b3 = b2 + a3;
      a4 = a3 + item.payload_length[15:8];
      b4 = b3 + a4;
      pa = sum_a_ff + item.payload_byte;
      pb = sum_b_ff + pa;
   end

   // Byte list and state update caused by the held word.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         exp_bytes[i] = '0;
      end
      exp_ends  = '0;
      exp_count = '0;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      left_in   = left_ff;
      open_in   = open_ff;
      if (item.operation == ubx_fb_pkg::OP_START) begin
         exp_bytes[0] = ubx_fb_pkg::SYNC_FIRST;
         exp_bytes[1] = ubx_fb_pkg::SYNC_SECOND;
         exp_bytes[2] = item.msg_class;
         exp_bytes[3] = item.msg_id;
         exp_bytes[4] = item.payload_length[7:0];
         exp_bytes[5] = item.payload_length[15:8];
         exp_bytes[6] = a4;
         exp_bytes[7] = b4;
         exp_ends[7]  = 1'b1;
         sum_a_in     = a4;
         sum_b_in     = b4;
         left_in      = item.payload_length;
         if (item.payload_length == 16'd0) begin
            exp_count = W'(8);
            open_in   = 1'b0;
         end else begin
            exp_count = W'(6);
            open_in   = 1'b1;
         end
      end else if (open_ff) begin
         exp_bytes[0] = item.payload_byte;
         exp_bytes[1] = pa;
         exp_bytes[2] = pb;
         exp_ends[2]  = 1'b1;
         sum_a_in     = pa;
         sum_b_in     = pb;
         left_in      = left_ff - 16'd1;
         if (left_ff == 16'd1) begin
            exp_count = W'(3);
            open_in   = 1'b0;
         end else begin
            exp_count = W'(1);
         end
      end
   end

   // Buffer loads on a take and shifts down on each sent byte.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         bytes_in[i] = bytes_ff[i];
      end
      ends_in  = ends_ff;
      count_in = count_ff;
      if (item_take) begin
         for (int i = 0; i < N; i++) begin
            bytes_in[i] = exp_bytes[i];
         end
         ends_in  = exp_ends;
         count_in = exp_count;
      end else if (emit) begin
         for (int i = 0; i < N - 1; i++) begin
            bytes_in[i] = bytes_ff[i + 1];
         end
         bytes_in[N-1] = '0;
         ends_in       = {1'b0, ends_ff[N-1:1]};
         count_in      = count_ff - W'(1);
      end
   end

   // Output valid follows each sent byte until the receiver takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         left_ff      <= '0;
         open_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_take) begin
            sum_a_ff <= sum_a_in;
            sum_b_ff <= sum_b_in;
            left_ff  <= left_in;
            open_ff  <= open_in;
         end
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Data registers carry no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         bytes_ff[i] <= bytes_in[i];
      end
      ends_ff <= ends_in;
      if (emit) begin
         rsp_byte_ff <= bytes_ff[0];
         rsp_end_ff  <= ends_ff[0];
         rsp_last_ff <= (count_ff == W'(1));
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_byte      = rsp_byte_ff;
   assign out_frame_end = rsp_end_ff;
   assign out_run_last  = rsp_last_ff;

endmodule

>>> rtl/core/ubx_frame_builder_unit.sv
// Top level of the UBX frame builder: request stream in, framed byte stream out.
//
// Usage: each request word is either a frame start (req_tuser = 0) with class,
// id and 16-bit payload length, or one payload byte (req_tuser = 1). A start
// word yields the sync bytes, class, id and length (low byte first), and when
// the length is zero also checksum A and B: 6 or 8 response words. A payload
// word of an open frame yields its byte, plus checksum A and B after the last
// counted byte: 1 or 3 words. A payload word with no frame open yields none.
// A start abandons any open frame. rsp_tlast marks the last word caused by a
// request word; rsp_tuser marks checksum B, the end of a frame.
// Path: a request word passes the input register, then the burst buffer, then
// the output register before its first response word appears. Throughput: one
// response word per cycle while rsp_tready stays high; payload bytes then stream
// at one per cycle. The burst buffer and its single output register set that.
// Reset clears the checksum, the byte count and any open frame, and empties
// all stages. When the receiver stalls, the output register holds its word,
// the burst buffer holds, and one more request word waits in the input register.
`timescale 1ns / 1ps

module ubx_frame_builder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] msg_class, [15:8] msg_id, [31:16] payload_length, [39:32] payload_byte
   input  logic [ubx_fb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] operation
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] out_byte
   output logic [ubx_fb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] frame_end
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   ubx_fb_pkg::item_type req_item;
   ubx_fb_pkg::item_type held_item;
   logic                 held_valid;
   logic                 held_take;

   // Unpack the request word.
   always_comb begin
      req_item.operation      = ubx_fb_pkg::op_type'(req_tuser);
      req_item.msg_class      = req_tdata[7:0];
      req_item.msg_id         = req_tdata[15:8];
      req_item.payload_length = req_tdata[31:16];
      req_item.payload_byte   = req_tdata[39:32];
   end

   // Input register.
   ubx_fb_hold u_hold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (held_valid),
      .out_take  (held_take),
      .out_item  (held_item)
   );

   // Framing core and output register.
   ubx_fb_core u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (held_valid),
      .item_take     (held_take),
      .item          (held_item),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (rsp_tdata),
      .out_frame_end (rsp_tuser),
      .out_run_last  (rsp_tlast)
   );

endmodule
